FILE: src/aavr_pkg.sv
// Shared types, constants and tables for the axis-angle vector rotation block.
`default_nettype none

package aavr_pkg;

    // Field widths
    localparam int COORD_WIDTH = 24;
    localparam int ANGLE_WIDTH = 16;

    // Axis normalization
    localparam int NORM_TOP   = 29;
    localparam int NORM_W     = NORM_TOP + 1;
    localparam int UNIT_FRAC  = 30;
    localparam int UNIT_W     = UNIT_FRAC + 2;
    localparam int SQ_W       = 2 * NORM_W + 2;
    localparam int SQRT_STEPS = SQ_W / 2 + 1;
    localparam int LEN_W      = SQRT_STEPS;
    localparam int DIV_STEPS  = UNIT_FRAC + 1;
    localparam int NORM_LAT   = 5 + SQRT_STEPS + 1 + DIV_STEPS + 1;

    // Half-angle trig, Q.28
    localparam int TRIG_W      = 32;
    localparam int HALF_SHIFT  = 14;
    localparam int TAB_LEN     = 24;
    localparam logic signed [TRIG_W-1:0] PI_Q28      = 32'sd843314857;
    localparam logic signed [TRIG_W-1:0] HALF_PI_Q28 = 32'sd421657428;
    localparam logic signed [TRIG_W-1:0] GAIN_Q28    = 32'sd163008219;

    localparam logic signed [TRIG_W-1:0] ARCTAN_Q28 [TAB_LEN] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32
    };

    // Rodrigues product pipeline
    localparam int W_SHIFT = UNIT_FRAC;
    localparam int T_SHIFT = 28;
    localparam int R_SHIFT = 27;
    localparam int ROD_LAT = 7;

    // Saturation limits
    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [UNIT_W-1:0]      t_unit;

    typedef struct packed {
        t_coord                         vec_x;
        t_coord                         vec_y;
        t_coord                         vec_z;
        t_coord                         axis_x;
        t_coord                         axis_y;
        t_coord                         axis_z;
        logic signed [ANGLE_WIDTH-1:0]  turn_angle;
    } t_req;

    typedef struct packed {
        t_coord rot_x;
        t_coord rot_y;
        t_coord rot_z;
        logic   saturated;
    } t_res;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos;
        logic signed [TRIG_W-1:0] sin;
    } t_trig;

endpackage

`default_nettype wire

FILE: src/aavr_norm.sv
// Axis normalization pipeline: magnitude scaling, square root and division.
`default_nettype none

module aavr_norm (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  aavr_pkg::t_coord      i_axis [3],
    output logic                  o_valid,
    output aavr_pkg::t_unit       o_unit [3]
);

    localparam int CW     = aavr_pkg::COORD_WIDTH;
    localparam int MAG_W  = CW;
    localparam int NW     = aavr_pkg::NORM_W;
    localparam int TOP_W  = $clog2(MAG_W);
    localparam int P_W    = 2 * NW;
    localparam int SQ_W   = aavr_pkg::SQ_W;
    localparam int RES_W  = SQ_W + 1;
    localparam int SSTEPS = aavr_pkg::SQRT_STEPS;
    localparam int LEN_W  = aavr_pkg::LEN_W;
    localparam int DSTEPS = aavr_pkg::DIV_STEPS;
    localparam int UW     = aavr_pkg::UNIT_W;
    localparam int LAT    = aavr_pkg::NORM_LAT;

    logic             r_vld [LAT];

    // stage A: magnitudes
    logic [MAG_W-1:0] r_a_mag [3];
    logic [2:0]       r_a_neg;
    // stage B: leading one of the largest magnitude
    logic [MAG_W-1:0] b_max;
    logic [TOP_W-1:0] b_top;
    logic [MAG_W-1:0] r_b_mag [3];
    logic [TOP_W-1:0] r_b_top;
    logic [2:0]       r_b_neg;
    // stage C: scaled magnitudes
    logic [MAG_W+NW-1:0] c_wide [3];
    logic [NW-1:0]    r_c_nm [3];
    logic [2:0]       r_c_neg;
    // stage D: squares
    logic [P_W-1:0]   r_d_sq [3];
    logic [NW-1:0]    r_d_nm [3];
    logic [2:0]       r_d_neg;
    // square root stages, index 0 holds the sum of squares
    logic [SQ_W-1:0]  r_sq_n   [SSTEPS+1];
    logic [RES_W-1:0] r_sq_res [SSTEPS+1];
    logic [NW-1:0]    r_sq_nm  [SSTEPS+1][3];
    logic [2:0]       r_sq_neg [SSTEPS+1];
    logic [RES_W-1:0] s_trial  [SSTEPS];
    // division stages, index 0 holds the initial remainder
    logic [LEN_W-1:0]  r_dv_rem [DSTEPS+1][3];
    logic [DSTEPS-1:0] r_dv_q   [DSTEPS+1][3];
    logic [LEN_W-1:0]  r_dv_len [DSTEPS+1];
    logic [2:0]        r_dv_neg [DSTEPS+1];
    logic [2:0]        r_dv_lsb;
    logic [LEN_W:0]    d_trial  [DSTEPS][3];
    logic              d_ge     [DSTEPS][3];
    // sign restore
    aavr_pkg::t_unit   r_u [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LAT; j++) r_vld[j] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int j = 1; j < LAT; j++) r_vld[j] <= r_vld[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a_neg[i] <= i_axis[i][CW-1];
            r_a_mag[i] <= i_axis[i][CW-1] ? MAG_W'(-i_axis[i]) : MAG_W'(i_axis[i]);
        end
    end

    always_comb begin
        b_max = r_a_mag[0];
        if (r_a_mag[1] > b_max) b_max = r_a_mag[1];
        if (r_a_mag[2] > b_max) b_max = r_a_mag[2];
        b_top = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (b_max[b]) b_top = TOP_W'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_mag <= r_a_mag;
        r_b_neg <= r_a_neg;
        r_b_top <= b_top;
    end

    // mag * 2^(NORM_TOP - top), truncating when the shift goes right
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_wide[i] = {r_b_mag[i], NW'(0)} >> (32'(r_b_top) + 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_c_nm[i] <= c_wide[i][NW-1:0];
            r_d_sq[i] <= P_W'(r_c_nm[i]) * P_W'(r_c_nm[i]);
        end
        r_c_neg <= r_b_neg;
        r_d_nm  <= r_c_nm;
        r_d_neg <= r_c_neg;
        r_sq_n[0]   <= SQ_W'(r_d_sq[0]) + SQ_W'(r_d_sq[1]) + SQ_W'(r_d_sq[2]);
        r_sq_res[0] <= '0;
        r_sq_nm[0]  <= r_d_nm;
        r_sq_neg[0] <= r_d_neg;
    end

    // digit-by-digit floor square root, one result bit per stage
    always_comb begin
        for (int k = 0; k < SSTEPS; k++) begin
            s_trial[k] = r_sq_res[k] + (RES_W'(1) << (2 * (SSTEPS - 1 - k)));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SSTEPS; k++) begin
            if (RES_W'(r_sq_n[k]) >= s_trial[k]) begin
                r_sq_n[k+1]   <= r_sq_n[k] - SQ_W'(s_trial[k]);
                r_sq_res[k+1] <= (r_sq_res[k] >> 1) + (RES_W'(1) << (2 * (SSTEPS - 1 - k)));
            end else begin
                r_sq_n[k+1]   <= r_sq_n[k];
                r_sq_res[k+1] <= r_sq_res[k] >> 1;
            end
            r_sq_nm[k+1]  <= r_sq_nm[k];
            r_sq_neg[k+1] <= r_sq_neg[k];
        end
    end

    // division setup: (nm << UNIT_FRAC) / len, len of zero taken as one
    always_ff @(posedge i_clk) begin
        r_dv_len[0] <= (r_sq_res[SSTEPS] == '0) ? LEN_W'(1) : r_sq_res[SSTEPS][LEN_W-1:0];
        r_dv_neg[0] <= r_sq_neg[SSTEPS];
        for (int i = 0; i < 3; i++) begin
            r_dv_rem[0][i] <= LEN_W'(r_sq_nm[SSTEPS][i] >> 1);
            r_dv_q[0][i]   <= '0;
            r_dv_lsb[i]    <= r_sq_nm[SSTEPS][i][0];
        end
    end

    // restoring division; only the first step pulls in a nonzero dividend bit
    always_comb begin
        for (int k = 0; k < DSTEPS; k++) begin
            for (int i = 0; i < 3; i++) begin
                d_trial[k][i] = {r_dv_rem[k][i], (k == 0) ? r_dv_lsb[i] : 1'b0};
                d_ge[k][i]    = d_trial[k][i] >= {1'b0, r_dv_len[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DSTEPS; k++) begin
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[k+1][i] <= d_ge[k][i] ? LEN_W'(d_trial[k][i] - {1'b0, r_dv_len[k]})
                                               : LEN_W'(d_trial[k][i]);
                r_dv_q[k+1][i]   <= {r_dv_q[k][i][DSTEPS-2:0], d_ge[k][i]};
            end
            r_dv_len[k+1] <= r_dv_len[k];
            r_dv_neg[k+1] <= r_dv_neg[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_u[i] <= r_dv_neg[DSTEPS][i] ? -UW'(r_dv_q[DSTEPS][i]) : UW'(r_dv_q[DSTEPS][i]);
        end
    end

    assign o_valid = r_vld[LAT-1];
    assign o_unit  = r_u;

endmodule

`default_nettype wire

FILE: src/aavr_cordic.sv
// Pipelined CORDIC giving cosine and sine of half the turn angle in Q.28.
`default_nettype none

module aavr_cordic #(
    parameter int ITERS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    input  logic signed [aavr_pkg::ANGLE_WIDTH-1:0]   i_angle,
    output logic                                      o_valid,
    output aavr_pkg::t_trig                           o_trig
);

    localparam int TW    = aavr_pkg::TRIG_W;
    localparam int STEPS = (ITERS < aavr_pkg::TAB_LEN) ? ITERS : aavr_pkg::TAB_LEN;
    localparam int LAT   = STEPS + 2;

    logic                 r_vld [LAT];
    logic signed [TW-1:0] r_x [STEPS+1];
    logic signed [TW-1:0] r_y [STEPS+1];
    logic signed [TW-1:0] r_z [STEPS+1];
    logic                 r_flip [STEPS+1];
    logic signed [TW-1:0] theta;
    aavr_pkg::t_trig      r_trig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LAT; j++) r_vld[j] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int j = 1; j < LAT; j++) r_vld[j] <= r_vld[j-1];
        end
    end

    assign theta = TW'(i_angle) <<< aavr_pkg::HALF_SHIFT;

    // fold into [-pi/2, pi/2]; the fold negates both outputs
    always_ff @(posedge i_clk) begin
        r_x[0] <= aavr_pkg::GAIN_Q28;
        r_y[0] <= '0;
        priority if (theta > aavr_pkg::HALF_PI_Q28) begin
            r_z[0]    <= theta - aavr_pkg::PI_Q28;
            r_flip[0] <= 1'b1;
        end else if (theta < -aavr_pkg::HALF_PI_Q28) begin
            r_z[0]    <= theta + aavr_pkg::PI_Q28;
            r_flip[0] <= 1'b1;
        end else begin
            r_z[0]    <= theta;
            r_flip[0] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STEPS; k++) begin
            if (r_z[k] >= 0) begin
                r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] - aavr_pkg::ARCTAN_Q28[k];
            end else begin
                r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                r_z[k+1] <= r_z[k] + aavr_pkg::ARCTAN_Q28[k];
            end
            r_flip[k+1] <= r_flip[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_trig.cos <= r_flip[STEPS] ? -r_x[STEPS] : r_x[STEPS];
        r_trig.sin <= r_flip[STEPS] ? -r_y[STEPS] : r_y[STEPS];
    end

    assign o_valid = r_vld[LAT-1];
    assign o_trig  = r_trig;

endmodule

`default_nettype wire

FILE: src/aavr_rodr.sv
// Euler-Rodrigues product pipeline with output saturation.
`default_nettype none

module aavr_rodr (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  aavr_pkg::t_unit    i_unit [3],
    input  aavr_pkg::t_trig    i_trig,
    input  aavr_pkg::t_coord   i_vec [3],
    output logic               o_valid,
    output aavr_pkg::t_res     o_res
);

    localparam int CW  = aavr_pkg::COORD_WIDTH;
    localparam int UW  = aavr_pkg::UNIT_W;
    localparam int TW  = aavr_pkg::TRIG_W;
    localparam int P1W = UW + TW;
    localparam int WW  = 32;
    localparam int P3W = WW + CW;
    localparam int TTW = 40;
    localparam int P5W = ((TW > WW) ? TW : WW) + TTW;
    localparam int AW  = 48;
    localparam int LAT = aavr_pkg::ROD_LAT;

    localparam logic signed [P1W-1:0] RND1 = P1W'(1) <<< (aavr_pkg::W_SHIFT - 1);
    localparam logic signed [P3W-1:0] RND3 = P3W'(1) <<< (aavr_pkg::T_SHIFT - 1);
    localparam logic signed [P5W-1:0] RND5 = P5W'(1) <<< (aavr_pkg::R_SHIFT - 1);

    logic                  r_vld [LAT];
    aavr_pkg::t_coord      r_v [LAT-1][3];
    logic signed [TW-1:0]  r_cos [4];
    logic signed [P1W-1:0] r_p1 [3];
    logic signed [WW-1:0]  r_w [3][3];
    logic signed [P3W-1:0] r_m [6];
    logic signed [TTW-1:0] r_t [3];
    logic signed [P5W-1:0] r_xt [3];
    logic signed [P5W-1:0] r_wt [6];
    logic signed [AW-1:0]  r_a [3];
    logic signed [AW-1:0]  r_b [3];
    logic signed [AW-1:0]  sum [3];
    aavr_pkg::t_coord      clip [3];
    logic [2:0]            over;
    aavr_pkg::t_res        r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LAT; j++) r_vld[j] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
            for (int j = 1; j < LAT; j++) r_vld[j] <= r_vld[j-1];
        end
    end

    // vector and cosine ride along
    always_ff @(posedge i_clk) begin
        r_v[0] <= i_vec;
        for (int j = 1; j < LAT - 1; j++) r_v[j] <= r_v[j-1];
        r_cos[0] <= i_trig.cos;
        for (int j = 1; j < 4; j++) r_cos[j] <= r_cos[j-1];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            // w = u * sin(angle/2)
            r_p1[i]   <= P1W'(i_unit[i]) * P1W'(i_trig.sin);
            r_w[0][i] <= WW'((r_p1[i] + RND1) >>> aavr_pkg::W_SHIFT);
            r_w[1][i] <= r_w[0][i];
            r_w[2][i] <= r_w[1][i];
        end
    end

    // t = w x v
    always_ff @(posedge i_clk) begin
        r_m[0] <= P3W'(r_w[0][1]) * P3W'(r_v[1][2]);
        r_m[1] <= P3W'(r_w[0][2]) * P3W'(r_v[1][1]);
        r_m[2] <= P3W'(r_w[0][2]) * P3W'(r_v[1][0]);
        r_m[3] <= P3W'(r_w[0][0]) * P3W'(r_v[1][2]);
        r_m[4] <= P3W'(r_w[0][0]) * P3W'(r_v[1][1]);
        r_m[5] <= P3W'(r_w[0][1]) * P3W'(r_v[1][0]);
        for (int i = 0; i < 3; i++) begin
            r_t[i] <= TTW'((r_m[2*i] - r_m[2*i+1] + RND3) >>> aavr_pkg::T_SHIFT);
        end
    end

    // cos * t and w x t
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_xt[i] <= P5W'(r_cos[3]) * P5W'(r_t[i]);
        end
        r_wt[0] <= P5W'(r_w[2][1]) * P5W'(r_t[2]);
        r_wt[1] <= P5W'(r_w[2][2]) * P5W'(r_t[1]);
        r_wt[2] <= P5W'(r_w[2][2]) * P5W'(r_t[0]);
        r_wt[3] <= P5W'(r_w[2][0]) * P5W'(r_t[2]);
        r_wt[4] <= P5W'(r_w[2][0]) * P5W'(r_t[1]);
        r_wt[5] <= P5W'(r_w[2][1]) * P5W'(r_t[0]);
        for (int i = 0; i < 3; i++) begin
            r_a[i] <= AW'((r_xt[i] + RND5) >>> aavr_pkg::R_SHIFT);
            r_b[i] <= AW'((r_wt[2*i] - r_wt[2*i+1] + RND5) >>> aavr_pkg::R_SHIFT);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sum[i] = AW'(r_v[LAT-2][i]) + r_a[i] + r_b[i];
            priority if (sum[i] > AW'(aavr_pkg::COORD_MAX)) begin
                clip[i] = aavr_pkg::COORD_MAX;
                over[i] = 1'b1;
            end else if (sum[i] < AW'(aavr_pkg::COORD_MIN)) begin
                clip[i] = aavr_pkg::COORD_MIN;
                over[i] = 1'b1;
            end else begin
                clip[i] = CW'(sum[i]);
                over[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.rot_x     <= clip[0];
        r_res.rot_y     <= clip[1];
        r_res.rot_z     <= clip[2];
        r_res.saturated <= |over;
    end

    assign o_valid = r_vld[LAT-1];
    assign o_res   = r_res;

endmodule

`default_nettype wire

FILE: src/axis_angle_vector_rotation.sv
// Top level of the axis-angle (Euler-Rodrigues) vector rotation pipeline.
//
// Rotates a Q7.16 vector about an axis of any length by a Q2.13 angle in
// radians. A request is taken on every clock edge where start is high;
// busy never rises, so one request per cycle is sustained indefinitely.
// Each result appears on o_result with o_valid high for one cycle, in
// request order. The pipeline depth is set by the axis normalization:
// 5 setup stages, a 32-stage square root, a divider setup stage, a
// 31-stage divider and a sign stage, followed by 7 stages of products and
// saturation. The half-angle CORDIC (TRIG_ITERATIONS rotation stages, at
// most 24) runs beside the normalizer on a delayed copy of the angle and
// does not add to the depth. A zero axis passes the vector unchanged.
// Components out of range clamp to the Q7.16 limits and set saturated.
// The receiver cannot stall: results must be taken when o_valid is high.
`default_nettype none

module axis_angle_vector_rotation #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  aavr_pkg::t_req  i_request,
    output logic            o_valid,
    output aavr_pkg::t_res  o_result
);

    localparam int STEPS      = (TRIG_ITERATIONS < aavr_pkg::TAB_LEN) ?
                                TRIG_ITERATIONS : aavr_pkg::TAB_LEN;
    localparam int CORDIC_LAT = STEPS + 2;
    localparam int NORM_LAT   = aavr_pkg::NORM_LAT;
    localparam int ANG_DLY    = NORM_LAT - CORDIC_LAT;
    localparam int TOTAL_LAT  = NORM_LAT + aavr_pkg::ROD_LAT;

    logic                                    accept;
    aavr_pkg::t_coord                        axis [3];
    aavr_pkg::t_coord                        r_vec_dly [NORM_LAT][3];
    logic signed [aavr_pkg::ANGLE_WIDTH-1:0] r_ang_dly [ANG_DLY];
    logic                                    r_ang_vld [ANG_DLY];
    logic                                    unit_valid;
    aavr_pkg::t_unit                         unit [3];
    logic                                    trig_valid;
    aavr_pkg::t_trig                         trig;

    // fully pipelined: never refuses a request
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign axis[0] = i_request.axis_x;
    assign axis[1] = i_request.axis_y;
    assign axis[2] = i_request.axis_z;

    // vector waits out the normalizer
    always_ff @(posedge i_clk) begin
        r_vec_dly[0][0] <= i_request.vec_x;
        r_vec_dly[0][1] <= i_request.vec_y;
        r_vec_dly[0][2] <= i_request.vec_z;
        for (int j = 1; j < NORM_LAT; j++) r_vec_dly[j] <= r_vec_dly[j-1];
    end

    // angle is delayed so the CORDIC finishes together with the unit axis
    always_ff @(posedge i_clk) begin
        r_ang_dly[0] <= i_request.turn_angle;
        for (int j = 1; j < ANG_DLY; j++) r_ang_dly[j] <= r_ang_dly[j-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < ANG_DLY; j++) r_ang_vld[j] <= 1'b0;
        end else begin
            r_ang_vld[0] <= accept;
            for (int j = 1; j < ANG_DLY; j++) r_ang_vld[j] <= r_ang_vld[j-1];
        end
    end

    aavr_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_axis  (axis),
        .o_valid (unit_valid),
        .o_unit  (unit)
    );

    aavr_cordic #(
        .ITERS (TRIG_ITERATIONS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_ang_vld[ANG_DLY-1]),
        .i_angle (r_ang_dly[ANG_DLY-1]),
        .o_valid (trig_valid),
        .o_trig  (trig)
    );

    aavr_rodr u_rodr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (unit_valid),
        .i_unit  (unit),
        .i_trig  (trig),
        .i_vec   (r_vec_dly[NORM_LAT-1]),
        .o_valid (o_valid),
        .o_res   (o_result)
    );

    // trig and unit axis of the same request meet in the product stages
    a_trig_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trig_valid == unit_valid)
        else $error("cordic and normalizer out of step");

    // every result comes from a request a fixed latency earlier
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, TOTAL_LAT))
        else $error("result without matching request");

    // the flag means some component sits at a limit
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.saturated) |->
        (o_result.rot_x == aavr_pkg::COORD_MAX || o_result.rot_x == aavr_pkg::COORD_MIN ||
         o_result.rot_y == aavr_pkg::COORD_MAX || o_result.rot_y == aavr_pkg::COORD_MIN ||
         o_result.rot_z == aavr_pkg::COORD_MAX || o_result.rot_z == aavr_pkg::COORD_MIN))
        else $error("saturated set with no clamped component");

    // zero axis: vector passes unchanged
    a_zero_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(start && i_request.axis_x == '0 && i_request.axis_y == '0 &&
                          i_request.axis_z == '0, TOTAL_LAT)) |->
        (o_result.rot_x == $past(i_request.vec_x, TOTAL_LAT) &&
         o_result.rot_y == $past(i_request.vec_y, TOTAL_LAT) &&
         o_result.rot_z == $past(i_request.vec_z, TOTAL_LAT) && !o_result.saturated))
        else $error("zero axis changed the vector");

endmodule

`default_nettype wire
